// ----- rtl/core/phop_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet header offset parser package
// Shared constants, protocol codes, the IPv6 walk phase type, the result
// record and the next-header classifier.
// ----------------------------------------------------------------------------
package phop_pkg;

    // Default frame length limit in bytes.
    localparam int MAX_FRAME_BYTES_DEF = 16384;

    // Largest end offset that fits the 14-bit result fields.
    localparam int END_LIMIT = 16383;

    // Ethernet layout.
    localparam int          ETH_TYPE_HI_POS = 12;
    localparam int          ETH_TYPE_LO_POS = 13;
    localparam int          LINK_HDR_BYTES  = 14;
    localparam int          VLAN_LINK_END   = 18;
    localparam logic [15:0] VLAN_TPID       = 16'h8100;

    // IP layout.
    localparam logic [3:0] IP_VERSION_4      = 4'd4;
    localparam logic [3:0] IP_VERSION_6      = 4'd6;
    localparam int         IPV4_PROTO_OFS    = 9;
    localparam int         IPV4_MIN_BYTES    = 10;
    localparam int         IPV6_NH_OFS       = 6;
    localparam int         IPV6_FIXED_BYTES  = 40;
    localparam int         IPV6_FRAG_BYTES   = 8;

    // Transport layout.
    localparam int TCP_DOFF_OFS   = 12;
    localparam int TCP_MIN_BYTES  = 13;
    localparam int UDP_HDR_BYTES  = 8;

    // Protocol and next-header codes.
    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
    localparam logic [7:0] PROTO_ESP      = 8'd50;
    localparam logic [7:0] PROTO_AH       = 8'd51;
    localparam logic [7:0] PROTO_ICMPV6   = 8'd58;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
    localparam logic [7:0] PROTO_UNKNOWN  = 8'd255;

    // Phase of the IPv6 extension header walk.
    typedef enum logic [2:0] {
        PH_WALK,
        PH_EXTLEN,
        PH_DONE,
        PH_SECURE,
        PH_FAIL
    } t_v6_phase;

    // One result record.
    typedef struct packed {
        logic [4:0]  link_end;
        logic        link_ok;
        logic [13:0] network_end;
        logic        network_ok;
        logic [13:0] transport_end;
        logic        transport_ok;
        logic [7:0]  upper_protocol;
        logic        too_long;
    } t_result;

    // Decide where the IPv6 walk goes after a next-header value.
    function automatic t_v6_phase classify_next(input logic [7:0] nh);
        t_v6_phase ph;
        case (nh)
            PROTO_TCP, PROTO_UDP, PROTO_ICMPV6: ph = PH_DONE;
            PROTO_HOPOPT, PROTO_ROUTING, PROTO_DSTOPTS, PROTO_FRAGMENT: ph = PH_WALK;
            PROTO_ESP, PROTO_AH: ph = PH_SECURE;
            default: ph = PH_FAIL;
        endcase
        return ph;
    endfunction

endpackage

// ----- rtl/core/phop_result.sv -----
// ----------------------------------------------------------------------------
// Packet header offset parser result stage
// Turns the captured header state of one finished frame into the result
// record and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module phop_result #(
    parameter  int MAX_FRAME_BYTES = phop_pkg::MAX_FRAME_BYTES_DEF,
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1),
    localparam int OFF_RAW         = $clog2(MAX_FRAME_BYTES + 4096),
    localparam int OFF_W           = (OFF_RAW > 15) ? OFF_RAW : 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_snap_valid,
    output logic                      o_snap_ready,
    input  logic [POS_W-1:0]          i_len,
    input  logic [4:0]                i_ip_start,
    input  logic [7:0]                i_version_ihl,
    input  logic [7:0]                i_ipv4_protocol,
    input  logic [7:0]                i_next_header,
    input  logic [OFF_W-1:0]          i_header_offset,
    input  phop_pkg::t_v6_phase       i_phase,
    input  logic [OFF_W-1:0]          i_transport_start,
    input  logic [3:0]                i_tcp_nibble,
    input  logic                      i_overflow,
    output logic                      o_valid,
    input  logic                      i_ready,
    output phop_pkg::t_result         o_result
);

    logic              r_valid;
    phop_pkg::t_result r_result;
    phop_pkg::t_result n_result;

    logic [OFF_W-1:0] len_off;
    logic [OFF_W-1:0] ip_off;
    logic [OFF_W-1:0] net_end;
    logic [OFF_W-1:0] tr_end;
    logic [OFF_W-1:0] start;
    logic [7:0]       proto;
    logic             link_ok;
    logic             net_ok;
    logic             tr_ok;
    logic             have;
    logic             load;

    assign len_off = OFF_W'(i_len);
    assign ip_off  = OFF_W'(i_ip_start);

    always_comb begin
        net_end = '0;
        tr_end  = '0;
        start   = '0;
        proto   = phop_pkg::PROTO_UNKNOWN;
        net_ok  = 1'b0;
        tr_ok   = 1'b0;
        have    = 1'b0;
        link_ok = len_off >= OFF_W'(phop_pkg::LINK_HDR_BYTES);

        if (link_ok && len_off >= ip_off + OFF_W'(1)) begin
            if (i_version_ihl[7:4] == phop_pkg::IP_VERSION_4) begin
                net_end = ip_off + OFF_W'({i_version_ihl[3:0], 2'b00});
                net_ok  = 1'b1;
                if (len_off >= ip_off + OFF_W'(phop_pkg::IPV4_MIN_BYTES)) begin
                    proto = i_ipv4_protocol;
                    start = i_transport_start;
                    have  = 1'b1;
                end
            end else if (i_version_ihl[7:4] == phop_pkg::IP_VERSION_6) begin
                if ((i_phase == phop_pkg::PH_DONE || i_phase == phop_pkg::PH_SECURE)
                        && i_header_offset <= len_off) begin
                    net_end = i_header_offset;
                    net_ok  = 1'b1;
                    if (i_phase == phop_pkg::PH_DONE) begin
                        proto = i_next_header;
                        start = i_transport_start;
                        have  = 1'b1;
                    end
                end
            end
            if (have) begin
                if (proto == phop_pkg::PROTO_TCP
                        && len_off >= start + OFF_W'(phop_pkg::TCP_MIN_BYTES)) begin
                    tr_end = start + OFF_W'({i_tcp_nibble, 2'b00});
                    tr_ok  = 1'b1;
                end else if (proto == phop_pkg::PROTO_UDP
                        && len_off >= start + OFF_W'(phop_pkg::UDP_HDR_BYTES)) begin
                    tr_end = start + OFF_W'(phop_pkg::UDP_HDR_BYTES);
                    tr_ok  = 1'b1;
                end
            end
        end

        // An end offset that does not fit the result field fails its layer.
        if (net_end > OFF_W'(phop_pkg::END_LIMIT)) begin
            net_ok = 1'b0;
        end
        if (tr_end > OFF_W'(phop_pkg::END_LIMIT)) begin
            tr_ok = 1'b0;
        end

        n_result.link_end       = link_ok ? i_ip_start : 5'd0;
        n_result.link_ok        = link_ok;
        n_result.network_end    = net_ok ? net_end[13:0] : 14'd0;
        n_result.network_ok     = net_ok;
        n_result.transport_end  = tr_ok ? tr_end[13:0] : 14'd0;
        n_result.transport_ok   = tr_ok;
        n_result.upper_protocol = proto;
        n_result.too_long       = i_overflow;
    end

    assign o_snap_ready = !r_valid || i_ready;
    assign load         = i_snap_valid && o_snap_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/core/packet_header_offset_parser_core.sv -----
// ----------------------------------------------------------------------------
// Packet header offset parser core
// Result path: the last byte of a frame is captured in the snapshot register,
//   and the result stage then forms the result record from it in its own register.
// Throughput: one frame byte per cycle unless a snapshot waits on the result
//   stage; the byte rate is set by the per-byte capture logic.
// Reset: synchronous, active low; clears the byte position, all captured
//   header state and both valid flags. The byte position and header state
//   are also cleared after the last byte of each frame.
// ----------------------------------------------------------------------------
module packet_header_offset_parser_core #(
    parameter int MAX_FRAME_BYTES = phop_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_link_end,
    output logic        o_link_ok,
    output logic [13:0] o_network_end,
    output logic        o_network_ok,
    output logic [13:0] o_transport_end,
    output logic        o_transport_ok,
    output logic [7:0]  o_upper_protocol,
    output logic        o_too_long
);

    // The byte position saturates at the frame limit, so it needs one value
    // more than the limit. Header offsets can run past the limit by at most
    // one extension header (2 KiB) plus a few fixed headers; they also must
    // be wide enough to compare against the largest reportable offset.
    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int OFF_RAW = $clog2(MAX_FRAME_BYTES + 4096);
    localparam int OFF_W   = (OFF_RAW > 15) ? OFF_RAW : 15;

    // ------------------------------------------------------------------------
    // Per-frame header tracking state
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]    r_pos,      n_pos;
    logic [7:0]          r_eth_hi,   n_eth_hi;
    logic [4:0]          r_ip_start, n_ip_start;
    logic [7:0]          r_vihl,     n_vihl;
    logic [7:0]          r_proto4,   n_proto4;
    logic [7:0]          r_nh,       n_nh;
    logic [OFF_W-1:0]    r_hoff,     n_hoff;
    phop_pkg::t_v6_phase r_phase,    n_phase;
    logic [OFF_W-1:0]    r_ts,       n_ts;
    logic [3:0]          r_nib,      n_nib;
    logic                r_over,     n_over;

    // Snapshot of the state after the last byte of a frame.
    logic                r_snap_valid;
    logic [POS_W-1:0]    r_s_len;
    logic [4:0]          r_s_ip_start;
    logic [7:0]          r_s_vihl;
    logic [7:0]          r_s_proto4;
    logic [7:0]          r_s_nh;
    logic [OFF_W-1:0]    r_s_hoff;
    phop_pkg::t_v6_phase r_s_phase;
    logic [OFF_W-1:0]    r_s_ts;
    logic [3:0]          r_s_nib;
    logic                r_s_over;

    logic                in_acc;
    logic                snap_take;
    logic [OFF_W-1:0]    p_off;
    logic [OFF_W-1:0]    ip_off;
    logic [OFF_W-1:0]    frag_next;
    logic [OFF_W-1:0]    ext_next;
    logic [3:0]          ver;
    phop_pkg::t_v6_phase ph_first;
    phop_pkg::t_v6_phase ph_frag;
    phop_pkg::t_v6_phase ph_ext;
    phop_pkg::t_result   result;

    // A new byte is taken whenever the snapshot register is free or is being
    // handed to the result stage in this cycle.
    assign o_in_ready = !r_snap_valid || snap_take;
    assign in_acc     = i_in_valid && o_in_ready;

    assign p_off     = OFF_W'(r_pos);
    assign ip_off    = OFF_W'(r_ip_start);
    assign ver       = r_vihl[7:4];
    assign frag_next = r_hoff + OFF_W'(phop_pkg::IPV6_FRAG_BYTES);
    // An extension header spans (length byte + 1) units of 8 bytes.
    assign ext_next  = r_hoff + OFF_W'({({1'b0, i_data_byte} + 9'd1), 3'b000});
    assign ph_first  = phop_pkg::classify_next(i_data_byte);
    assign ph_frag   = phop_pkg::classify_next(i_data_byte);
    assign ph_ext    = phop_pkg::classify_next(r_nh);

    // ------------------------------------------------------------------------
    // Next value of the tracking state for the byte on the input. Every
    // capture compares the current byte position with an offset already
    // known, so each byte is a handful of parallel compares and adds.
    // The header version used here is the one captured before this byte.
    // ------------------------------------------------------------------------
    always_comb begin
        n_pos      = r_pos;
        n_eth_hi   = r_eth_hi;
        n_ip_start = r_ip_start;
        n_vihl     = r_vihl;
        n_proto4   = r_proto4;
        n_nh       = r_nh;
        n_hoff     = r_hoff;
        n_phase    = r_phase;
        n_ts       = r_ts;
        n_nib      = r_nib;
        n_over     = r_over;

        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + POS_W'(1);

            // Ethertype, and the link header length that follows from it.
            if (p_off == OFF_W'(phop_pkg::ETH_TYPE_HI_POS)) begin
                n_eth_hi = i_data_byte;
            end
            if (p_off == OFF_W'(phop_pkg::ETH_TYPE_LO_POS)) begin
                n_ip_start = ({r_eth_hi, i_data_byte} == phop_pkg::VLAN_TPID)
                           ? 5'(phop_pkg::VLAN_LINK_END) : 5'(phop_pkg::LINK_HDR_BYTES);
            end

            // TCP data offset nibble.
            if ((ver == phop_pkg::IP_VERSION_4
                    || (ver == phop_pkg::IP_VERSION_6 && r_phase == phop_pkg::PH_DONE))
                    && p_off == r_ts + OFF_W'(phop_pkg::TCP_DOFF_OFS)) begin
                n_nib = i_data_byte[7:4];
            end

            // First byte of the IP header: version and IHL.
            if (p_off >= OFF_W'(phop_pkg::LINK_HDR_BYTES) && p_off == ip_off) begin
                n_vihl = i_data_byte;
                if (i_data_byte[7:4] == phop_pkg::IP_VERSION_4) begin
                    n_ts = ip_off + OFF_W'({i_data_byte[3:0], 2'b00});
                end
            end

            // IPv4 protocol byte.
            if (ver == phop_pkg::IP_VERSION_4
                    && p_off == ip_off + OFF_W'(phop_pkg::IPV4_PROTO_OFS)) begin
                n_proto4 = i_data_byte;
            end

            // IPv6 next header and the extension header walk.
            if (ver == phop_pkg::IP_VERSION_6) begin
                if (p_off == ip_off + OFF_W'(phop_pkg::IPV6_NH_OFS)) begin
                    n_nh    = i_data_byte;
                    n_hoff  = ip_off + OFF_W'(phop_pkg::IPV6_FIXED_BYTES);
                    n_phase = ph_first;
                    if (ph_first == phop_pkg::PH_DONE) begin
                        n_ts = ip_off + OFF_W'(phop_pkg::IPV6_FIXED_BYTES);
                    end
                end else if (p_off > ip_off + OFF_W'(phop_pkg::IPV6_NH_OFS)) begin
                    if (r_phase == phop_pkg::PH_WALK && p_off == r_hoff) begin
                        n_nh = i_data_byte;
                        if (r_nh == phop_pkg::PROTO_FRAGMENT) begin
                            // The fragment header has a fixed length.
                            n_hoff  = frag_next;
                            n_phase = ph_frag;
                            if (ph_frag == phop_pkg::PH_DONE) begin
                                n_ts = frag_next;
                            end
                        end else begin
                            n_phase = phop_pkg::PH_EXTLEN;
                        end
                    end else if (r_phase == phop_pkg::PH_EXTLEN
                            && p_off == r_hoff + OFF_W'(1)) begin
                        n_hoff  = ext_next;
                        n_phase = ph_ext;
                        if (ph_ext == phop_pkg::PH_DONE) begin
                            n_ts = ext_next;
                        end
                    end
                end
            end
        end else begin
            // Bytes past the limit are dropped and only flagged.
            n_over = 1'b1;
        end
    end

    // Tracking state: back to its initial values after every last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last_byte)) begin
            r_pos      <= '0;
            r_eth_hi   <= '0;
            r_ip_start <= 5'(phop_pkg::LINK_HDR_BYTES);
            r_vihl     <= '0;
            r_proto4   <= phop_pkg::PROTO_UNKNOWN;
            r_nh       <= '0;
            r_hoff     <= '0;
            r_phase    <= phop_pkg::PH_WALK;
            r_ts       <= '0;
            r_nib      <= '0;
            r_over     <= 1'b0;
        end else if (in_acc) begin
            r_pos      <= n_pos;
            r_eth_hi   <= n_eth_hi;
            r_ip_start <= n_ip_start;
            r_vihl     <= n_vihl;
            r_proto4   <= n_proto4;
            r_nh       <= n_nh;
            r_hoff     <= n_hoff;
            r_phase    <= n_phase;
            r_ts       <= n_ts;
            r_nib      <= n_nib;
            r_over     <= n_over;
        end
    end

    // Snapshot valid flag: set by a last byte, cleared when the result stage
    // takes the snapshot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    // Snapshot payload holds the state including the last byte.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_s_len      <= n_pos;
            r_s_ip_start <= n_ip_start;
            r_s_vihl     <= n_vihl;
            r_s_proto4   <= n_proto4;
            r_s_nh       <= n_nh;
            r_s_hoff     <= n_hoff;
            r_s_phase    <= n_phase;
            r_s_ts       <= n_ts;
            r_s_nib      <= n_nib;
            r_s_over     <= n_over;
        end
    end

    // ------------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------------
    phop_result #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_snap_valid      (r_snap_valid),
        .o_snap_ready      (snap_take),
        .i_len             (r_s_len),
        .i_ip_start        (r_s_ip_start),
        .i_version_ihl     (r_s_vihl),
        .i_ipv4_protocol   (r_s_proto4),
        .i_next_header     (r_s_nh),
        .i_header_offset   (r_s_hoff),
        .i_phase           (r_s_phase),
        .i_transport_start (r_s_ts),
        .i_tcp_nibble      (r_s_nib),
        .i_overflow        (r_s_over),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_result          (result)
    );

    assign o_link_end       = result.link_end;
    assign o_link_ok        = result.link_ok;
    assign o_network_end    = result.network_end;
    assign o_network_ok     = result.network_ok;
    assign o_transport_end  = result.transport_end;
    assign o_transport_ok   = result.transport_ok;
    assign o_upper_protocol = result.upper_protocol;
    assign o_too_long       = result.too_long;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The byte position never runs past the frame limit.
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position past frame limit");

    // A last byte restarts the position count for the next frame.
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> (r_pos == '0))
        else $error("byte position not cleared after last byte");

    // A snapshot handed to the result stage shows up as a valid result.
    a_snap_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && snap_take) |=> o_out_valid)
        else $error("snapshot taken but no result");

    // A good link layer ends at 14 or 18 bytes.
    a_link_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_link_ok) |->
            (o_link_end == 5'(phop_pkg::LINK_HDR_BYTES)
             || o_link_end == 5'(phop_pkg::VLAN_LINK_END)))
        else $error("bad link end offset");

    // A failed network or transport layer reports a zero end offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_network_ok || o_network_end == 14'd0)
                         && (o_transport_ok || o_transport_end == 14'd0)))
        else $error("failed layer with nonzero end offset");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header offset parser testbench
// Sends whole frames, one byte per request, and runs a byte-level model of
// the header walk next to the core. The model predicts the offsets and flags
// reported on each last byte. A checker compares every reported result, field
// by field, with the oldest prediction. Directed frames cover short frames,
// VLAN, IPv4 and IPv6 with extension chains, security headers, unknown
// versions and overlong frames. Random frames follow, with idle cycles and
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    import phop_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int FRAME_BUF_BYTES  = 16400;
    localparam int RAND_FILL_BYTES  = 256;
    localparam int GAP_PERCENT      = 11;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_FRAMES    = 60;
    localparam int RANDOM_BYTES     = 450;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP4      = 8'd1;
    localparam logic [7:0]  PROTO_UNASSIGNED = 8'd99;
    localparam logic [3:0]  IP_VERSION_ST    = 4'd5;
    localparam logic [3:0]  IP_VERSION_RSVD  = 4'hF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [4:0]  o_link_end;
    logic        o_link_ok;
    logic [13:0] o_network_end;
    logic        o_network_ok;
    logic [13:0] o_transport_end;
    logic        o_transport_ok;
    logic [7:0]  o_upper_protocol;
    logic        o_too_long;

    packet_header_offset_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_link_end      (o_link_end),
        .o_link_ok       (o_link_ok),
        .o_network_end   (o_network_end),
        .o_network_ok    (o_network_ok),
        .o_transport_end (o_transport_end),
        .o_transport_ok  (o_transport_ok),
        .o_upper_protocol(o_upper_protocol),
        .o_too_long      (o_too_long)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    t_result     pending_offsets[$];
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned cycle_count = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_gaps_on = 1'b1;
    bit          sink_held = 1'b0;
    event        start_long_hold;

    // Frame under construction. It is filled with random bytes first and the
    // header fields are then written at their offsets.
    logic [7:0]  frame_buf [FRAME_BUF_BYTES];

    // ------------------------------------------------------------------------
    // Header walk model
    // ------------------------------------------------------------------------
    int unsigned walk_pos;
    logic [15:0] etype_acc;
    int unsigned ip_ofs;
    logic [7:0]  vihl;
    logic [7:0]  v4_proto;
    logic [7:0]  cur_nh;
    int unsigned hdr_ofs;
    logic [7:0]  ext_len;
    t_v6_phase   v6_phase;
    int unsigned l4_start;
    logic [3:0]  tcp_doff;
    bit          overflowed;

    function automatic void clear_walk();
        walk_pos   = 0;
        etype_acc  = '0;
        ip_ofs     = LINK_HDR_BYTES;
        vihl       = '0;
        v4_proto   = PROTO_UNKNOWN;
        cur_nh     = '0;
        hdr_ofs    = 0;
        ext_len    = '0;
        v6_phase   = PH_WALK;
        l4_start   = 0;
        tcp_doff   = '0;
        overflowed = 1'b0;
    endfunction

    // Decides where the IPv6 walk goes once a next-header value is known.
    function automatic void route_next_header();
        case (cur_nh)
            PROTO_TCP, PROTO_UDP, PROTO_ICMPV6: begin
                v6_phase = PH_DONE;
                l4_start = hdr_ofs;
            end
            PROTO_HOPOPT, PROTO_ROUTING, PROTO_DSTOPTS, PROTO_FRAGMENT: begin
                v6_phase = PH_WALK;
            end
            PROTO_ESP, PROTO_AH: begin
                v6_phase = PH_SECURE;
            end
            default: begin
                v6_phase = PH_FAIL;
            end
        endcase
    endfunction

    // Captures whatever this byte position holds. The version seen here is the
    // one from before this byte, so the IP version byte itself never starts
    // the protocol captures.
    function automatic void capture_byte(input int unsigned p, input logic [7:0] b);
        logic [3:0] ver_now;
        ver_now = vihl[7:4];
        if (p == ETH_TYPE_HI_POS) begin
            etype_acc = {b, 8'h00};
        end
        if (p == ETH_TYPE_LO_POS) begin
            etype_acc[7:0] = b;
            ip_ofs = (etype_acc == VLAN_TPID) ? VLAN_LINK_END : LINK_HDR_BYTES;
        end
        if ((ver_now == IP_VERSION_4 || (ver_now == IP_VERSION_6 && v6_phase == PH_DONE))
                && p == l4_start + TCP_DOFF_OFS) begin
            tcp_doff = b[7:4];
        end
        if (p >= LINK_HDR_BYTES && p == ip_ofs) begin
            vihl = b;
            if (b[7:4] == IP_VERSION_4) begin
                l4_start = ip_ofs + b[3:0] * 4;
            end
        end
        if (ver_now == IP_VERSION_4 && p == ip_ofs + IPV4_PROTO_OFS) begin
            v4_proto = b;
        end
        if (ver_now == IP_VERSION_6) begin
            if (p == ip_ofs + IPV6_NH_OFS) begin
                cur_nh = b;
                hdr_ofs = ip_ofs + IPV6_FIXED_BYTES;
                route_next_header();
            end else if (p > ip_ofs + IPV6_NH_OFS) begin
                if (v6_phase == PH_WALK && p == hdr_ofs) begin
                    // A fragment header has a fixed size, the others carry a
                    // length byte right after the next-header byte.
                    if (cur_nh == PROTO_FRAGMENT) begin
                        cur_nh = b;
                        hdr_ofs += IPV6_FRAG_BYTES;
                        route_next_header();
                    end else begin
                        cur_nh = b;
                        v6_phase = PH_EXTLEN;
                    end
                end else if (v6_phase == PH_EXTLEN && p == hdr_ofs + 1) begin
                    ext_len = b;
                    hdr_ofs += (ext_len + 1) * 8;
                    route_next_header();
                end
            end
        end
    endfunction

    // Advances the model by one accepted request and, on the last byte of a
    // frame, queues the offsets the core has to report.
    function automatic void absorb_byte(input logic [7:0] b, input bit last);
        t_result     r;
        int unsigned flen, net_e, l4_e, l4_s;
        bit          net_ok, l4_ok, have_l4;
        logic [7:0]  proto;
        logic [3:0]  ver;
        if (walk_pos < MAX_FRAME_BYTES_DEF) begin
            capture_byte(walk_pos, b);
            walk_pos++;
        end else begin
            overflowed = 1'b1;
        end
        if (!last) begin
            return;
        end
        flen = walk_pos;
        net_e = 0;
        l4_e = 0;
        l4_s = 0;
        net_ok = 1'b0;
        l4_ok = 1'b0;
        have_l4 = 1'b0;
        proto = PROTO_UNKNOWN;
        r = '0;
        r.link_ok = (flen >= LINK_HDR_BYTES);
        if (r.link_ok) begin
            r.link_end = ip_ofs[4:0];
        end
        ver = vihl[7:4];
        if (r.link_ok && flen >= ip_ofs + 1) begin
            if (ver == IP_VERSION_4) begin
                net_e = ip_ofs + vihl[3:0] * 4;
                net_ok = 1'b1;
                if (flen >= ip_ofs + IPV4_MIN_BYTES) begin
                    proto = v4_proto;
                    l4_s = l4_start;
                    have_l4 = 1'b1;
                end
            end else if (ver == IP_VERSION_6) begin
                if ((v6_phase == PH_DONE || v6_phase == PH_SECURE) && hdr_ofs <= flen) begin
                    net_e = hdr_ofs;
                    net_ok = 1'b1;
                    if (v6_phase == PH_DONE) begin
                        proto = cur_nh;
                        l4_s = l4_start;
                        have_l4 = 1'b1;
                    end
                end
            end
            if (have_l4) begin
                if (proto == PROTO_TCP && flen >= l4_s + TCP_MIN_BYTES) begin
                    l4_e = l4_s + tcp_doff * 4;
                    l4_ok = 1'b1;
                end else if (proto == PROTO_UDP && flen >= l4_s + UDP_HDR_BYTES) begin
                    l4_e = l4_s + UDP_HDR_BYTES;
                    l4_ok = 1'b1;
                end
            end
        end
        // An end offset that does not fit the 14-bit field fails its layer.
        if (net_e > END_LIMIT) begin
            net_ok = 1'b0;
        end
        if (l4_e > END_LIMIT) begin
            l4_ok = 1'b0;
        end
        r.network_end    = net_ok ? net_e[13:0] : '0;
        r.network_ok     = net_ok;
        r.transport_end  = l4_ok ? l4_e[13:0] : '0;
        r.transport_ok   = l4_ok;
        r.upper_protocol = proto;
        r.too_long       = overflowed;
        pending_offsets.push_back(r);
        clear_walk();
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: outputs are sampled at the rising edge.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_offsets.size() == 0) begin
                $error("result reported with no frame waiting for one");
                mismatch_count++;
            end else begin
                want = pending_offsets.pop_front();
                check_field("link_end", want.link_end, o_link_end);
                check_field("link_ok", want.link_ok, o_link_ok);
                check_field("network_end", want.network_end, o_network_end);
                check_field("network_ok", want.network_ok, o_network_ok);
                check_field("transport_end", want.transport_end, o_transport_end);
                check_field("transport_ok", want.transport_ok, o_transport_ok);
                check_field("upper_protocol", want.upper_protocol, o_upper_protocol);
                check_field("too_long", want.too_long, o_too_long);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_held) begin
            i_out_ready <= 1'b0;
        end else if (sink_gaps_on) begin
            i_out_ready <= ($urandom_range(0, 99) >= GAP_PERCENT);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(start_long_hold);
            @(posedge i_clk);
            sink_held = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            sink_held = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------------
    function automatic void fill_frame(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            frame_buf[i] = $urandom_range(0, 255);
        end
    endfunction

    function automatic void fill_const(input int unsigned n, input logic [7:0] val);
        for (int unsigned i = 0; i < n; i++) begin
            frame_buf[i] = val;
        end
    endfunction

    // Writes the ethertype, behind a VLAN tag if asked, and returns where the
    // IP header starts.
    function automatic int unsigned put_link(input bit vlan, input logic [15:0] etype);
        if (vlan) begin
            frame_buf[ETH_TYPE_HI_POS] = VLAN_TPID[15:8];
            frame_buf[ETH_TYPE_LO_POS] = VLAN_TPID[7:0];
            frame_buf[VLAN_LINK_END - 2] = etype[15:8];
            frame_buf[VLAN_LINK_END - 1] = etype[7:0];
            return VLAN_LINK_END;
        end
        frame_buf[ETH_TYPE_HI_POS] = etype[15:8];
        frame_buf[ETH_TYPE_LO_POS] = etype[7:0];
        return LINK_HDR_BYTES;
    endfunction

    function automatic int unsigned put_ipv4(input int unsigned ip, input logic [3:0] ihl,
                                             input logic [7:0] proto);
        frame_buf[ip] = {IP_VERSION_4, ihl};
        frame_buf[ip + IPV4_PROTO_OFS] = proto;
        return ip + ihl * 4;
    endfunction

    function automatic int unsigned put_ipv6(input int unsigned ip, input logic [7:0] nh);
        frame_buf[ip] = {IP_VERSION_6, frame_buf[ip][3:0]};
        frame_buf[ip + IPV6_NH_OFS] = nh;
        return ip + IPV6_FIXED_BYTES;
    endfunction

    function automatic int unsigned put_ext(input int unsigned ofs, input logic [7:0] nh,
                                            input logic [7:0] len8);
        frame_buf[ofs] = nh;
        frame_buf[ofs + 1] = len8;
        return ofs + (len8 + 1) * 8;
    endfunction

    function automatic int unsigned put_frag(input int unsigned ofs, input logic [7:0] nh);
        frame_buf[ofs] = nh;
        return ofs + IPV6_FRAG_BYTES;
    endfunction

    function automatic void put_tcp(input int unsigned ofs, input logic [3:0] doff);
        frame_buf[ofs + TCP_DOFF_OFS] = {doff, frame_buf[ofs + TCP_DOFF_OFS][3:0]};
    endfunction

    // Builds a random frame: mostly well-formed headers with random content,
    // some truncated, some pure noise.
    task automatic make_random_frame(output int unsigned len);
        int unsigned pick, ip, ofs, need, n_ext;
        logic [7:0]  chain [4];
        logic [7:0]  last_proto;
        logic [7:0]  nh_after;
        bit          vlan;
        pick = $urandom_range(0, 99);
        vlan = ($urandom_range(0, 3) == 0);
        fill_frame(RAND_FILL_BYTES);
        if (pick < 15) begin
            len = $urandom_range(1, 90);
            return;
        end
        if (pick < 55) begin
            ip = put_link(vlan, ETYPE_IPV4);
            case ($urandom_range(0, 3))
                0: last_proto = PROTO_TCP;
                1: last_proto = PROTO_UDP;
                2: last_proto = PROTO_ICMP4;
                default: last_proto = $urandom_range(0, 255);
            endcase
            ofs = put_ipv4(ip, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(5, 15),
                           last_proto);
            need = (ofs > ip + IPV4_MIN_BYTES) ? ofs : ip + IPV4_MIN_BYTES;
        end else begin
            ip = put_link(vlan, ETYPE_IPV6);
            n_ext = $urandom_range(0, 3);
            for (int i = 0; i < n_ext; i++) begin
                case ($urandom_range(0, 3))
                    0: chain[i] = PROTO_HOPOPT;
                    1: chain[i] = PROTO_ROUTING;
                    2: chain[i] = PROTO_DSTOPTS;
                    default: chain[i] = PROTO_FRAGMENT;
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2: last_proto = PROTO_TCP;
                3, 4, 5: last_proto = PROTO_UDP;
                6: last_proto = PROTO_ICMPV6;
                7: last_proto = PROTO_ESP;
                8: last_proto = PROTO_AH;
                default: last_proto = $urandom_range(0, 255);
            endcase
            ofs = put_ipv6(ip, (n_ext > 0) ? chain[0] : last_proto);
            for (int i = 0; i < n_ext; i++) begin
                nh_after = (i + 1 < n_ext) ? chain[i + 1] : last_proto;
                if (chain[i] == PROTO_FRAGMENT) begin
                    ofs = put_frag(ofs, nh_after);
                end else begin
                    ofs = put_ext(ofs, nh_after, $urandom_range(0, 3));
                end
            end
            need = ofs;
        end
        if (last_proto == PROTO_TCP) begin
            put_tcp(ofs, $urandom_range(0, 15));
            if (ofs + 20 > need) need = ofs + 20;
        end else if (last_proto == PROTO_UDP) begin
            if (ofs + UDP_HDR_BYTES > need) need = ofs + UDP_HDR_BYTES;
        end
        len = need + $urandom_range(0, 16);
        if ($urandom_range(0, 99) < 15) begin
            len = $urandom_range(1, need);
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offers one byte and waits until the core accepts it. Inputs change at
    // the falling edge only, and valid is never dropped while a byte waits.
    task automatic send_byte(input logic [7:0] b, input bit last);
        @(negedge i_clk);
        while (src_gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(frame_buf[i], i == len - 1);
        end
        frames_sent++;
    endtask

    // Stops offering requests until every predicted result has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Frames too short for the link header, the IP version byte or the IPv4 protocol byte.
    task automatic test_short_frames();
        int unsigned ip;
        fill_const(1, 8'h00);
        send_frame(1);
        fill_const(13, 8'hFF);
        send_frame(13);
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        send_frame(14);
        ip = put_ipv4(ip, 4'd5, PROTO_TCP);
        send_frame(15);
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b1, ETYPE_IPV4);
        send_frame(VLAN_LINK_END);
        wait_results_drained();
    endtask

    task automatic test_ipv4_frames();
        int unsigned ip, l4;
        // Plain TCP with a minimal header and some payload.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd5, PROTO_TCP);
        put_tcp(l4, 4'd5);
        send_frame(l4 + 28);
        // UDP behind a VLAN tag, ending exactly on the UDP header.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b1, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd5, PROTO_UDP);
        send_frame(l4 + UDP_HDR_BYTES);
        // A protocol that has no transport end.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd6, PROTO_ICMP4);
        send_frame(l4 + 12);
        // Largest IHL and largest TCP data offset.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd15, PROTO_TCP);
        put_tcp(l4, 4'd15);
        send_frame(l4 + 60);
        // IHL of zero: the transport header starts on the IP header itself.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd0, PROTO_UDP);
        send_frame(ip + 20);
        // Frame ends just before the protocol byte.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd5, PROTO_TCP);
        send_frame(ip + IPV4_PROTO_OFS);
        // TCP header one byte short of the data offset field.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b1, ETYPE_IPV4);
        l4 = put_ipv4(ip, 4'd5, PROTO_TCP);
        put_tcp(l4, 4'd6);
        send_frame(l4 + TCP_MIN_BYTES - 1);
        wait_results_drained();
    endtask

    task automatic test_ipv6_frames();
        int unsigned ip, o;
        // TCP right after the fixed header.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_TCP);
        put_tcp(o, 4'd8);
        send_frame(o + 32);
        // Every extension header type in one chain, then UDP.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b1, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_HOPOPT);
        o = put_ext(o, PROTO_ROUTING, 8'd0);
        o = put_ext(o, PROTO_DSTOPTS, 8'd1);
        o = put_ext(o, PROTO_FRAGMENT, 8'd0);
        o = put_frag(o, PROTO_UDP);
        send_frame(o + UDP_HDR_BYTES);
        // Largest extension length, ending in ICMPv6.
        fill_frame(2200);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_DSTOPTS);
        o = put_ext(o, PROTO_ICMPV6, 8'd255);
        send_frame(o + 16);
        // ESP straight after the fixed header.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_ESP);
        send_frame(o + 30);
        // AH after hop-by-hop options.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_HOPOPT);
        o = put_ext(o, PROTO_AH, 8'd2);
        send_frame(o + 24);
        // Next header the walk does not know.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_UNASSIGNED);
        send_frame(o + 20);
        // Extension header running past the end of the frame.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_ROUTING);
        o = put_ext(o, PROTO_UDP, 8'd3);
        send_frame(o - 4);
        // IP versions that are neither 4 nor 6.
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b0, ETYPE_IPV4);
        frame_buf[ip] = {IP_VERSION_ST, 4'd5};
        send_frame(ip + 40);
        fill_frame(RAND_FILL_BYTES);
        ip = put_link(1'b1, ETYPE_IPV6);
        frame_buf[ip] = {IP_VERSION_RSVD, 4'hF};
        send_frame(ip + 40);
        wait_results_drained();
    endtask

    // Frames at and beyond the length limit, sent with no idle cycles at all.
    task automatic test_long_frames();
        int unsigned ip, o;
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        // Overlong IPv6 frame whose TCP end no longer fits the offset field.
        fill_frame(FRAME_BUF_BYTES);
        ip = put_link(1'b0, ETYPE_IPV6);
        o = put_ipv6(ip, PROTO_HOPOPT);
        for (int i = 0; i < 7; i++) begin
            o = put_ext(o, PROTO_HOPOPT, 8'd255);
        end
        o = put_ext(o, PROTO_TCP, 8'd241);
        put_tcp(o, 4'd15);
        send_frame(FRAME_BUF_BYTES);
        // A frame of exactly the maximum length is not overlong.
        fill_frame(MAX_FRAME_BYTES_DEF);
        ip = put_link(1'b0, ETYPE_IPV4);
        o = put_ipv4(ip, 4'd5, PROTO_UDP);
        send_frame(MAX_FRAME_BYTES_DEF);
        wait_results_drained();
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // The result side holds off while frames keep coming, so the core has
    // to stall its request side.
    task automatic test_backpressure();
        int unsigned len;
        -> start_long_hold;
        for (int i = 0; i < 12; i++) begin
            make_random_frame(len);
            send_frame(len);
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned len, n_frames, n_bytes;
        n_frames = 0;
        n_bytes = 0;
        while (n_frames < RANDOM_FRAMES || n_bytes < RANDOM_BYTES) begin
            make_random_frame(len);
            send_frame(len);
            n_frames++;
            n_bytes += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_walk();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_ipv4_frames();
        test_ipv6_frames();
        test_long_frames();
        test_backpressure();
        test_random_traffic();

        // Wait out the result path with margin, so that a stray
        // extra result would still be caught.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d bytes in %0d frames, %0d results checked, %0d mismatches",
                 bytes_sent, frames_sent, results_checked, mismatch_count);
        $display("tb: short, VLAN, IPv4, IPv6 chains, security and overlong frames, stalls");
        if (mismatch_count == 0 && pending_offsets.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
